[sv/assert_macros.svh]
// Assertion helpers shared by the RTL. Both sample on clk and stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define DHST_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DHST_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dhst_pkg.sv]
package dhst_pkg;

  localparam int DHST_MAX_SLOTS = 64;

  localparam int CMD_W    = 3;
  localparam int ID_W     = 6;
  localparam int IDX_W    = 6;
  localparam int HANDLE_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  localparam logic [HANDLE_W-1:0] HANDLE_CLOSED = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD        = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_DISCONNECT = 3'd2,
    CMD_LOOKUP     = 3'd3,
    CMD_READ_SLOT  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2,
    ST_NEG  = 2'd3
  } status_t;

endpackage

[sv/dhst_ram.sv]
module dhst_ram
  import dhst_pkg::*;
#(
  parameter int Depth = DHST_MAX_SLOTS,
  parameter int Width = HANDLE_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata_r
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

[sv/dhst_id_pool.sv]
module dhst_id_pool
  import dhst_pkg::*;
#(
  parameter int MaxSlots = DHST_MAX_SLOTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        alloc_en,
  input  logic [$clog2(MaxSlots)-1:0] alloc_id,
  input  logic                        free_en,
  input  logic [$clog2(MaxSlots)-1:0] free_id,
  input  logic [$clog2(MaxSlots)-1:0] qry_id,
  output logic                        qry_used,
  output logic                        low_free_ok_r,
  output logic [$clog2(MaxSlots)-1:0] low_free_id_r
);

  localparam int SW = $clog2(MaxSlots);

  logic [MaxSlots-1:0] used_r;
  logic                lf_ok;
  logic [SW-1:0]       lf_id;

  assign qry_used = used_r[qry_id];

  // lowest free id, registered from the used bits, which are themselves registered
  always_comb begin
    lf_ok = 1'b0;
    lf_id = '0;
    for (int i = MaxSlots - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        lf_ok = 1'b1;
        lf_id = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r        <= '0;
      low_free_ok_r <= 1'b0;
    end else begin
      if (alloc_en) begin
        used_r[alloc_id] <= 1'b1;
      end
      if (free_en) begin
        used_r[free_id] <= 1'b0;
      end
      low_free_ok_r <= lf_ok;
    end
  end

  always_ff @(posedge clk) begin
    low_free_id_r <= lf_id;
  end

endmodule

[sv/dense_handle_slot_table.sv]
// Dense handle slot table: handles kept packed in slots 0..count-1, addressed by stable ids.
// Each accepted command steps through S_LOOK, then S_SLOT (lookup, disconnect, remove with a
// valid id), S_LAST (remove), and S_DONE until the result word is loaded; the id and slot
// memories have registered reads. A new command is taken only after that load (in_stall).
// Reset (rst_n low, synchronous): count to zero, every id free, no word held at the output;
// memory contents are not cleared, as stale entries are never reached.
`include "assert_macros.svh"

module dense_handle_slot_table
  import dhst_pkg::*;
#(
  parameter int MAX_SLOTS = DHST_MAX_SLOTS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // command words
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [CMD_W-1:0]           in_command,
  input  logic [ID_W-1:0]            in_entry_id,
  input  logic [IDX_W-1:0]           in_slot_index,
  input  logic signed [HANDLE_W-1:0] in_new_handle,
  // result words
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [ID_W-1:0]            out_result_id,
  output logic signed [HANDLE_W-1:0] out_result_handle,
  output logic [COUNT_W-1:0]         out_entry_count
);

  // slot / id index width, live count width
  localparam int SW    = $clog2(MAX_SLOTS);
  localparam int CW    = $clog2(MAX_SLOTS + 1);
  localparam int CmpW  = ((CW > ID_W) ? CW : ID_W) + 1;
  // slot memory word: {owning id, handle}
  localparam int SlotW = SW + HANDLE_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,   // waiting for a command word
    S_LOOK = 5'b00010,   // id map (and slot for read-by-index) data back
    S_SLOT = 5'b00100,   // slot of the named id back
    S_LAST = 5'b01000,   // remove: last slot back, move it into the hole
    S_DONE = 5'b10000    // result ready, waits for the output register
  } state_t;

  state_t state_r, state_nxt;

  // captured command word
  logic [CMD_W-1:0]    cmd_r;
  logic [ID_W-1:0]     eid_r;
  logic [IDX_W-1:0]    sidx_r;
  logic [HANDLE_W-1:0] hnd_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] s_r, s_nxt;

  status_t             res_status_r, res_status_nxt;
  logic [ID_W-1:0]     res_id_r, res_id_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;

  status_t             out_status_r;
  logic [ID_W-1:0]     out_id_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_valid_r;

  // slot memory ports
  logic             slot_we;
  logic [SW-1:0]    slot_waddr, slot_raddr;
  logic [SlotW-1:0] slot_wdata, slot_rdata;
  logic [SW-1:0]    slot_rd_id;
  logic [HANDLE_W-1:0] slot_rd_hnd;

  // id -> slot memory ports
  logic          id_we;
  logic [SW-1:0] id_waddr, id_wdata, id_raddr, id_rdata;

  // id pool
  logic          alloc_en, free_en, qry_used, free_ok;
  logic [SW-1:0] alloc_id, free_id, low_free_id;

  logic accept, out_load, id_ok, sidx_ok;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  assign slot_rd_id  = slot_rdata[SlotW-1:HANDLE_W];
  assign slot_rd_hnd = slot_rdata[HANDLE_W-1:0];

  // id map is read straight off the input word so its data lands in S_LOOK
  assign id_raddr = SW'(in_entry_id);

  // a named id must be in range and allocated
  assign id_ok   = (CmpW'(eid_r) < CmpW'(MAX_SLOTS)) && qry_used;
  assign sidx_ok = CmpW'(sidx_r) < CmpW'(count_r);

  dhst_ram #(
    .Depth (MAX_SLOTS),
    .Width (SlotW)
  ) u_slot_ram (
    .clk     (clk),
    .we      (slot_we),
    .waddr   (slot_waddr),
    .wdata   (slot_wdata),
    .raddr   (slot_raddr),
    .rdata_r (slot_rdata)
  );

  dhst_ram #(
    .Depth (MAX_SLOTS),
    .Width (SW)
  ) u_id_ram (
    .clk     (clk),
    .we      (id_we),
    .waddr   (id_waddr),
    .wdata   (id_wdata),
    .raddr   (id_raddr),
    .rdata_r (id_rdata)
  );

  dhst_id_pool #(
    .MaxSlots (MAX_SLOTS)
  ) u_id_pool (
    .clk           (clk),
    .rst_n         (rst_n),
    .alloc_en      (alloc_en),
    .alloc_id      (alloc_id),
    .free_en       (free_en),
    .free_id       (free_id),
    .qry_id        (SW'(eid_r)),
    .qry_used      (qry_used),
    .low_free_ok_r (free_ok),
    .low_free_id_r (low_free_id)
  );

  // slot read address follows the sequence: index from the port, then the
  // mapped slot, then the last live slot for a remove
  always_comb begin
    case (state_r)
      S_IDLE:  slot_raddr = SW'(in_slot_index);
      S_LOOK:  slot_raddr = id_rdata;
      S_SLOT:  slot_raddr = SW'(count_r - CW'(1));
      default: slot_raddr = s_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    s_nxt          = s_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_handle_nxt = res_handle_r;
    slot_we        = 1'b0;
    slot_waddr     = s_r;
    slot_wdata     = slot_rdata;
    id_we          = 1'b0;
    id_waddr       = slot_rd_id;
    id_wdata       = s_r;
    alloc_en       = 1'b0;
    alloc_id       = low_free_id;
    free_en        = 1'b0;
    free_id        = SW'(eid_r);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        res_status_nxt = ST_BAD;
        res_id_nxt     = '0;
        res_handle_nxt = '0;
        state_nxt      = S_DONE;
        case (cmd_r)
          CMD_ADD: begin
            if (hnd_r[HANDLE_W-1]) begin
              res_status_nxt = ST_NEG;
            end else if (!free_ok || (count_r >= CW'(MAX_SLOTS))) begin
              res_status_nxt = ST_FULL;
            end else begin
              // append at the tail slot under the lowest free id
              slot_we        = 1'b1;
              slot_waddr     = SW'(count_r);
              slot_wdata     = {low_free_id, hnd_r};
              id_we          = 1'b1;
              id_waddr       = low_free_id;
              id_wdata       = SW'(count_r);
              alloc_en       = 1'b1;
              count_nxt      = count_r + CW'(1);
              res_status_nxt = ST_OK;
              res_id_nxt     = ID_W'(low_free_id);
              res_handle_nxt = hnd_r;
            end
          end
          CMD_READ_SLOT: begin
            if (sidx_ok) begin
              res_status_nxt = ST_OK;
              res_id_nxt     = ID_W'(slot_rd_id);
              res_handle_nxt = slot_rd_hnd;
            end
          end
          CMD_REMOVE, CMD_DISCONNECT, CMD_LOOKUP: begin
            if (id_ok) begin
              s_nxt     = id_rdata;
              state_nxt = S_SLOT;
            end
          end
          default: begin
            res_status_nxt = ST_BAD;
          end
        endcase
      end

      S_SLOT: begin
        res_status_nxt = ST_OK;
        res_id_nxt     = eid_r;
        res_handle_nxt = slot_rd_hnd;
        state_nxt      = S_DONE;
        case (cmd_r)
          CMD_DISCONNECT: begin
            // close in place, entry stays live
            slot_we    = 1'b1;
            slot_wdata = {slot_rd_id, HANDLE_CLOSED};
          end
          CMD_REMOVE: begin
            state_nxt = S_LAST;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_LAST: begin
        // last slot fills the hole; its id now points at the hole. When the
        // hole is the last slot the writes land beyond the live range.
        slot_we   = 1'b1;
        id_we     = 1'b1;
        free_en   = 1'b1;
        count_nxt = count_r - CW'(1);
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      eid_r  <= in_entry_id;
      sidx_r <= in_slot_index;
      hnd_r  <= in_new_handle;
    end
    s_r          <= s_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_handle_r <= res_handle_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_handle_r <= res_handle_r;
      out_count_r  <= COUNT_W'(count_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_result_id     = out_id_r;
  assign out_result_handle = out_handle_r;
  assign out_entry_count   = out_count_r;

  `DHST_ASSERT_NEXT(a_add_grows, (state_r == S_LOOK) && (cmd_r == CMD_ADD) && (res_status_nxt == ST_OK), count_r == $past(count_r) + CW'(1), "successful add did not grow the count")
  `DHST_ASSERT_NEXT(a_remove_shrinks, state_r == S_LAST, count_r == $past(count_r) - CW'(1), "remove did not shrink the count")
  `DHST_ASSERT_SAME(a_out_from_done, $rose(out_valid_r), $past(state_r == S_DONE), "result word appeared without a finished command")

endmodule
